// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL. All use clk and rst from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/met_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

  localparam int FRAC_BITS = 28;
  localparam logic signed [31:0] FOUR_Q = 32'sh4000_0000;

  // config register indexes
  localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [2:0] REG_STEP_RE   = 3'd2;
  localparam logic [2:0] REG_STEP_IM   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER  = 3'd4;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
  } req_t;

  typedef struct packed {
    logic [15:0] escape_count;
    logic        in_set;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRE,   // col * step_re
    S_CIM,   // row * step_im, form c.re
    S_CI,    // form c.im, clear z
    S_RR,    // zr * zr
    S_II,    // zi * zi
    S_RI,    // zr * zi
    S_UPD,   // magnitude test, new zi
    S_ADD,   // new zr, limit test
    S_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // arithmetic shift right is floor division by 2^sh
  function automatic logic signed [31:0] prod_q(input logic signed [63:0] p,
                                                input int unsigned sh);
    logic signed [63:0] t;
    t = p >>> sh;
    return sat32(t);
  endfunction

endpackage

`default_nettype wire

// ===== design/mandelbrot_escape_time_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                 Handshake
// request   start, busy, req (col,row)            taken when start && !busy
// result    done, result (escape_count,in_set)    one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   valid && ready (ready only when idle)
//
// One request: setup states S_CRE, S_CIM and S_CI, then rounds of S_RR, S_II, S_RI,
// S_UPD and S_ADD (none when the limit is 0; a round that escapes ends at S_UPD), then
// the S_DONE result cycle; the next request can be taken the cycle after done. The
// single shared 32x32 multiplier forms every product: three per round plus the two
// coordinate products of setup.
// busy is high from the cycle after accept through the done cycle.
// Synchronous reset returns to idle and loads the default view and a limit of 256.
// The result is held for the done cycle only; the receiver cannot stall it.

module mandelbrot_escape_time_unit
  import met_pkg::*;
#(
  parameter int GRID_SIDE = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             done,
  output rsp_t             result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

`include "assert_macros.svh"

  localparam int GRID_MAX = GRID_SIDE - 1;

  // configuration registers
  logic signed [31:0] origin_re;
  logic signed [31:0] origin_im;
  logic signed [31:0] step_re;
  logic signed [31:0] step_im;
  logic [15:0]        max_iterations;

  state_t state, state_next;

  // working registers
  logic [9:0]         col;
  logic [9:0]         row;
  logic signed [31:0] cr, ci, zr, zi;
  logic signed [31:0] re2, im2, diff;
  logic signed [63:0] prod;
  logic [15:0]        count;

  // shared multiplier operands
  logic signed [31:0] mul_a, mul_b;

  logic               accept;
  logic signed [31:0] mag;
  logic signed [31:0] cross2;
  logic               escape;
  logic [9:0]         col_clamped, row_clamped;
  logic               in_round;

  // registers only change between requests, never under a request in flight
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign in_round  = state inside {S_RR, S_II, S_RI, S_UPD};

  // indexes past the grid clamp to its last line
  always_comb begin
    col_clamped = req.col;
    row_clamped = req.row;
    if ({3'b000, req.col} > 13'(GRID_MAX)) begin
      col_clamped = 10'(GRID_MAX);
    end
    if ({3'b000, req.row} > 13'(GRID_MAX)) begin
      row_clamped = 10'(GRID_MAX);
    end
  end

  // round arithmetic: prod holds zr*zi in S_UPD, scaled by 2^27 for the doubled term
  assign cross2 = prod_q(prod, FRAC_BITS - 1);
  assign mag    = sat_add(re2, im2);
  assign escape = mag > FOUR_Q;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re      <= -32'sd536870912;
      origin_im      <= -32'sd402653184;
      step_re        <= 32'sd786432;
      step_im        <= 32'sd786432;
      max_iterations <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_RE: origin_re      <= cfg_data;
        REG_ORIGIN_IM: origin_im      <= cfg_data;
        REG_STEP_RE:   step_re        <= cfg_data;
        REG_STEP_IM:   step_im        <= cfg_data;
        REG_MAX_ITER:  max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_CRE;
      S_CRE:  state_next = S_CIM;
      S_CIM:  state_next = S_CI;
      S_CI:   state_next = (max_iterations == 16'd0) ? S_DONE : S_RR;
      S_RR:   state_next = S_II;
      S_II:   state_next = S_RI;
      S_RI:   state_next = S_UPD;
      S_UPD:  state_next = escape ? S_DONE : S_ADD;
      S_ADD:  state_next = (count == max_iterations) ? S_DONE : S_RR;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    busy  = (state != S_IDLE);
    done  = (state == S_DONE);
    mul_a = zr;
    mul_b = zr;
    case (state)
      S_CRE: begin
        mul_a = {22'd0, col};
        mul_b = step_re;
      end
      S_CIM: begin
        mul_a = {22'd0, row};
        mul_b = step_im;
      end
      S_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_RI: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: ;
    endcase
  end

  assign result.escape_count = count;
  assign result.in_set       = (count == max_iterations);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    case (state)
      S_IDLE: begin
        if (accept) begin
          col <= col_clamped;
          row <= row_clamped;
        end
      end
      S_CIM: cr <= sat32({{32{origin_re[31]}}, origin_re} + prod);
      S_CI: begin
        ci    <= sat32({{32{origin_im[31]}}, origin_im} + prod);
        zr    <= '0;
        zi    <= '0;
        count <= '0;
      end
      S_II: re2 <= prod_q(prod, FRAC_BITS);
      S_RI: im2 <= prod_q(prod, FRAC_BITS);
      S_UPD: begin
        diff <= sat_sub(re2, im2);
        zi   <= sat_add(cross2, ci);
        if (!escape) begin
          count <= count + 16'd1;
        end
      end
      S_ADD: zr <= sat_add(diff, cr);
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_done_to_idle, done, !busy, "result cycle not followed by idle")
  `ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted request did not start work")
  `ASSERT_SAME(a_count_bound, in_round, count < max_iterations, "round started past the limit")
  `ASSERT_SAME(a_count_final, (state == S_ADD), count <= max_iterations, "count passed the limit")

endmodule

`default_nettype wire
